### src/fltpm_pkg.sv
// Shared constants and types for the four-level page table mapper.
package fltpm_pkg;

    localparam int TABLE_FRAMES      = 64;   // power of two
    localparam int ENTRIES_PER_TABLE = 512;

    localparam int ADDR_W     = 52;
    localparam int VA_W       = 48;
    localparam int FLAGS_W    = 12;
    localparam int PAGE_SHIFT = 12;
    localparam int PFN_W      = ADDR_W - PAGE_SHIFT;
    localparam int IDX_W      = $clog2(ENTRIES_PER_TABLE);
    localparam int FRAME_W    = $clog2(TABLE_FRAMES);
    localparam int NFF_W      = $clog2(TABLE_FRAMES + 1);
    localparam int MEM_DEPTH  = TABLE_FRAMES * ENTRIES_PER_TABLE;
    localparam int MEM_AW     = FRAME_W + IDX_W;
    localparam int ENTRY_W    = ADDR_W;
    localparam int LEVEL_W    = 2;
    localparam int ADDED_W    = 2;

    // Low bits of an intermediate table entry: present, writable, user.
    localparam logic [PAGE_SHIFT-1:0] TABLE_ENTRY_BITS = PAGE_SHIFT'('h7);
    localparam int PRESENT_BIT = 0;

    localparam logic [LEVEL_W-1:0] LEVEL_TOP  = LEVEL_W'(3);
    localparam logic [LEVEL_W-1:0] LEVEL_LAST = LEVEL_W'(1);

    localparam logic STATUS_FULL = 1'b1;

    // Datapath controls decoded from the current microcode step.
    typedef struct packed {
        logic idle;
        logic clear_wr;
        logic mem_rd;
        logic eval;
        logic leaf_wr;
        logic done;
    } ctrl_t;

    // Conditions the sequencer branches on.
    typedef struct packed {
        logic start;
        logic present;
        logic pool_full;
        logic last_level;
        logic clear_last;
    } cond_t;

endpackage

### src/four_level_page_table_mapper.sv
// Top level: four-level page table mapper with internal table memory.
// done pulses in the result step, which follows the leaf write, or follows the evaluate
// step of the level where the pool runs dry; a new transaction is taken the cycle after done.
// The order is set by the microcode: one read step and one evaluate step per table level,
// then a leaf write and a result step; a new request waits until the result is given.
// After reset the table memory is swept to zero, one entry per cycle over all 32768 entries,
// with busy high; table_base writes are taken throughout. Results cannot be stalled.
module four_level_page_table_mapper
(
    input  logic                                clk,
    input  logic                                rst_n,

    // request channel
    input  logic                                start,
    output logic                                busy,
    input  logic [fltpm_pkg::VA_W-1:0]          virt_addr,
    input  logic [fltpm_pkg::ADDR_W-1:0]        phys_addr,
    input  logic [fltpm_pkg::FLAGS_W-1:0]       flags,

    // result strobe
    output logic                                done,
    output logic                                status,
    output logic [fltpm_pkg::ADDED_W-1:0]       tables_added,

    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fltpm_pkg::ADDR_W-1:0]        table_base
);

    fltpm_pkg::ctrl_t ctrl;
    fltpm_pkg::cond_t cond;

    // Request registers, held for the whole walk.
    logic [fltpm_pkg::VA_W-1:0]     va_reg;
    logic [fltpm_pkg::ADDR_W-1:0]   pa_reg;
    logic [fltpm_pkg::FLAGS_W-1:0]  flags_reg;

    // Walk state.
    logic [fltpm_pkg::LEVEL_W-1:0]  lvl_reg;
    logic [fltpm_pkg::FRAME_W-1:0]  frame_reg;
    logic [fltpm_pkg::ADDED_W-1:0]  added_reg;
    logic                           status_reg;
    logic [fltpm_pkg::NFF_W-1:0]    nff_reg;
    logic [fltpm_pkg::MEM_AW-1:0]   clr_cnt_reg;
    logic [fltpm_pkg::ADDR_W-1:0]   table_base_reg;

    // Table memory and its registered read data.
    logic [fltpm_pkg::ENTRY_W-1:0]  table_mem [fltpm_pkg::MEM_DEPTH];
    logic [fltpm_pkg::ENTRY_W-1:0]  rdata_reg;

    logic [fltpm_pkg::IDX_W-1:0]    walk_idx;
    logic [fltpm_pkg::IDX_W-1:0]    leaf_idx;
    logic [fltpm_pkg::PFN_W-1:0]    base_pfn;
    logic [fltpm_pkg::PFN_W-1:0]    alloc_pfn;
    logic [fltpm_pkg::PFN_W-1:0]    entry_pfn;
    logic [fltpm_pkg::FRAME_W-1:0]  entry_frame;
    logic                           present;
    logic                           pool_full;
    logic                           alloc;
    logic                           mem_we;
    logic [fltpm_pkg::MEM_AW-1:0]   mem_waddr;
    logic [fltpm_pkg::ENTRY_W-1:0]  mem_wdata;
    logic [fltpm_pkg::MEM_AW-1:0]   walk_addr;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign cond.start      = start;
    assign cond.present    = present;
    assign cond.pool_full  = pool_full;
    assign cond.last_level = (lvl_reg == fltpm_pkg::LEVEL_LAST);
    assign cond.clear_last = (clr_cnt_reg == fltpm_pkg::MEM_AW'(fltpm_pkg::MEM_DEPTH - 1));

    fltpm_sequencer u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    // Only the idle step takes a request; clearing and walking both hold it off.
    assign busy      = ~ctrl.idle;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Address and entry arithmetic
    // ------------------------------------------------------------------
    // Select the 9-bit index for the current level: bits 47:39, 38:30, 29:21.
    assign walk_idx  = va_reg[fltpm_pkg::PAGE_SHIFT + fltpm_pkg::IDX_W * int'(lvl_reg)
                              +: fltpm_pkg::IDX_W];
    assign leaf_idx  = va_reg[fltpm_pkg::PAGE_SHIFT +: fltpm_pkg::IDX_W];
    assign walk_addr = {frame_reg, walk_idx};

    // The low 12 bits of the base are ignored, so work in frame numbers.
    assign base_pfn  = table_base_reg[fltpm_pkg::ADDR_W-1:fltpm_pkg::PAGE_SHIFT];
    assign alloc_pfn = base_pfn + fltpm_pkg::PFN_W'(nff_reg);

    // A present entry maps back to a pool frame: (pfn - base_pfn) mod TABLE_FRAMES.
    // With a power-of-two pool only the low frame bits of the difference matter.
    assign entry_pfn   = rdata_reg[fltpm_pkg::ADDR_W-1:fltpm_pkg::PAGE_SHIFT];
    assign entry_frame = entry_pfn[fltpm_pkg::FRAME_W-1:0] - base_pfn[fltpm_pkg::FRAME_W-1:0];

    assign present   = rdata_reg[fltpm_pkg::PRESENT_BIT];
    assign pool_full = (nff_reg >= fltpm_pkg::NFF_W'(fltpm_pkg::TABLE_FRAMES));
    assign alloc     = ctrl.eval & ~present & ~pool_full;

    // ------------------------------------------------------------------
    // Table memory write port: clearing sweep, new table pointer, leaf entry.
    // ------------------------------------------------------------------
    assign mem_we = ctrl.clear_wr | alloc | ctrl.leaf_wr;

    always_comb
    begin
        priority if (ctrl.clear_wr)
        begin
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (ctrl.leaf_wr)
        begin
            mem_waddr = {frame_reg, leaf_idx};
            mem_wdata = pa_reg | fltpm_pkg::ENTRY_W'(flags_reg);
        end
        else
        begin
            // Same slot the lookup just read.
            mem_waddr = walk_addr;
            mem_wdata = {alloc_pfn, fltpm_pkg::TABLE_ENTRY_BITS};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[mem_waddr] <= mem_wdata;
        if (ctrl.mem_rd)
            rdata_reg <= table_mem[walk_addr];
    end

    // ------------------------------------------------------------------
    // Request capture (payload, no reset needed)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ctrl.idle && start)
        begin
            va_reg    <= virt_addr;
            pa_reg    <= phys_addr;
            flags_reg <= flags;
        end
    end

    // ------------------------------------------------------------------
    // Walk control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg        <= '0;
            frame_reg      <= '0;
            added_reg      <= '0;
            status_reg     <= 1'b0;
            nff_reg        <= fltpm_pkg::NFF_W'(1);
            clr_cnt_reg    <= '0;
            table_base_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                table_base_reg <= table_base;

            // Advance the clearing sweep one entry per cycle.
            if (ctrl.clear_wr)
                clr_cnt_reg <= clr_cnt_reg + fltpm_pkg::MEM_AW'(1);

            // New transaction: start at the top table, frame 0.
            if (ctrl.idle && start)
            begin
                lvl_reg    <= fltpm_pkg::LEVEL_TOP;
                frame_reg  <= '0;
                added_reg  <= '0;
                status_reg <= 1'b0;
            end

            if (ctrl.eval)
            begin
                lvl_reg <= lvl_reg - fltpm_pkg::LEVEL_W'(1);
                if (present)
                    frame_reg <= entry_frame;
                else if (!pool_full)
                begin
                    // Take the next free frame and link it in.
                    frame_reg <= nff_reg[fltpm_pkg::FRAME_W-1:0];
                    nff_reg   <= nff_reg + fltpm_pkg::NFF_W'(1);
                    added_reg <= added_reg + fltpm_pkg::ADDED_W'(1);
                end
                else
                    // Pool exhausted: drop the leaf, keep tables added so far.
                    status_reg <= fltpm_pkg::STATUS_FULL;
            end
        end
    end

    assign done         = ctrl.done;
    assign status       = status_reg;
    assign tables_added = added_reg;

`ifndef SYNTHESIS
    a_nff_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        nff_reg <= fltpm_pkg::NFF_W'(fltpm_pkg::TABLE_FRAMES))
        else $error("frame allocator ran past the pool");

    a_fail_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> pool_full)
        else $error("failure reported while frames remain");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    a_alloc_counts: assert property (@(posedge clk) disable iff (!rst_n)
        alloc |=> (nff_reg == $past(nff_reg) + fltpm_pkg::NFF_W'(1)))
        else $error("allocation did not advance the free frame pointer");
`endif

endmodule

### src/fltpm_sequencer.sv
// Microcode sequencer: step counter, control ROM and jump logic.
module fltpm_sequencer
(
    input  logic                clk,
    input  logic                rst_n,
    input  fltpm_pkg::cond_t    cond,
    output fltpm_pkg::ctrl_t    ctrl
);

    typedef logic [2:0] step_t;

    localparam step_t STEP_CLEAR = 3'd0;
    localparam step_t STEP_IDLE  = 3'd1;
    localparam step_t STEP_READ  = 3'd2;
    localparam step_t STEP_EVAL  = 3'd3;
    localparam step_t STEP_LEAF  = 3'd4;
    localparam step_t STEP_DONE  = 3'd5;

    typedef enum logic [1:0] {
        JMP_NEXT  = 2'd0,
        JMP_START = 2'd1,
        JMP_CLEAR = 2'd2,
        JMP_EVAL  = 2'd3
    } jmp_t;

    typedef struct packed {
        fltpm_pkg::ctrl_t ctrl;
        jmp_t             jmp;
        step_t            next;   // taken target
        step_t            alt;    // walk abort target
        step_t            loop;   // next level target
    } ucode_t;

    function automatic ucode_t ucode_rom(step_t s);
        ucode_t u;
        begin
            u = '0;
            u.jmp  = JMP_NEXT;
            u.next = STEP_IDLE;
            u.alt  = STEP_IDLE;
            u.loop = STEP_IDLE;
            unique case (s)
                STEP_CLEAR:
                begin
                    u.ctrl.clear_wr = 1'b1;
                    u.jmp           = JMP_CLEAR;
                    u.next          = STEP_IDLE;
                end
                STEP_IDLE:
                begin
                    u.ctrl.idle = 1'b1;
                    u.jmp       = JMP_START;
                    u.next      = STEP_READ;
                end
                STEP_READ:
                begin
                    u.ctrl.mem_rd = 1'b1;
                    u.next        = STEP_EVAL;
                end
                STEP_EVAL:
                begin
                    u.ctrl.eval = 1'b1;
                    u.jmp       = JMP_EVAL;
                    u.next      = STEP_LEAF;
                    u.alt       = STEP_DONE;
                    u.loop      = STEP_READ;
                end
                STEP_LEAF:
                begin
                    u.ctrl.leaf_wr = 1'b1;
                    u.next         = STEP_DONE;
                end
                STEP_DONE:
                begin
                    u.ctrl.done = 1'b1;
                    u.next      = STEP_IDLE;
                end
                default:
                begin
                    u.next = STEP_IDLE;
                end
            endcase
            return u;
        end
    endfunction

    step_t  step_reg;
    step_t  step_next;
    ucode_t uword;

    assign uword = ucode_rom(step_reg);
    assign ctrl  = uword.ctrl;

    always_comb
    begin
        unique case (uword.jmp)
            JMP_NEXT:  step_next = uword.next;
            JMP_START: step_next = cond.start ? uword.next : step_reg;
            JMP_CLEAR: step_next = cond.clear_last ? uword.next : step_reg;
            JMP_EVAL:
            begin
                priority if (!cond.present && cond.pool_full)
                    step_next = uword.alt;
                else if (cond.last_level)
                    step_next = uword.next;
                else
                    step_next = uword.loop;
            end
            default:   step_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_CLEAR;
        else
            step_reg <= step_next;
    end

`ifndef SYNTHESIS
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.done |=> ctrl.idle)
        else $error("sequencer left the done step somewhere other than idle");

    a_leaf_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.leaf_wr |-> $past(ctrl.eval))
        else $error("leaf write without a preceding lookup");

    a_read_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.mem_rd |=> ctrl.eval)
        else $error("table read not followed by evaluation");
`endif

endmodule

### test/four_level_page_table_mapper_test.sv
// Testbench for the four-level page table mapper: queued driver, clocked checker.
module four_level_page_table_mapper_test;

    timeunit 1ns;
    timeprecision 1ps;

    // A refused mapping reports STATUS_FULL; anything else means the leaf went in.
    localparam logic STATUS_MAPPED = ~fltpm_pkg::STATUS_FULL;

    // Largest 4 KiB aligned pool base that fits in 52 bits.
    localparam logic [fltpm_pkg::ADDR_W-1:0] BASE_TOP =
        {{fltpm_pkg::PFN_W{1'b1}}, {fltpm_pkg::PAGE_SHIFT{1'b0}}};

    // Bits 47:21 of a virtual address select the leaf table.
    localparam int PATH_W = fltpm_pkg::VA_W - fltpm_pkg::PAGE_SHIFT - fltpm_pkg::IDX_W;

    localparam int PHASES         = 7;
    localparam int ITEMS_PER_PHASE = 265;
    localparam int MAX_REPORTS    = 100;

    typedef struct packed {
        logic [fltpm_pkg::VA_W-1:0]    va;
        logic [fltpm_pkg::ADDR_W-1:0]  pa;
        logic [fltpm_pkg::FLAGS_W-1:0] fl;
    } map_req_t;

    typedef struct packed {
        logic [fltpm_pkg::VA_W-1:0]    va;
        logic                          status;
        logic [fltpm_pkg::ADDED_W-1:0] added;
    } map_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic [fltpm_pkg::VA_W-1:0]      virt_addr;
    logic [fltpm_pkg::ADDR_W-1:0]    phys_addr;
    logic [fltpm_pkg::FLAGS_W-1:0]   flags;
    logic                            done;
    logic                            status;
    logic [fltpm_pkg::ADDED_W-1:0]   tables_added;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [fltpm_pkg::ADDR_W-1:0]    table_base;

    // Shadow copy of the block's state: table memory, allocator and pool base.
    logic [fltpm_pkg::ADDR_W-1:0]    page_tables [0:fltpm_pkg::MEM_DEPTH-1];
    int                              alloc_ptr = 1;
    logic [fltpm_pkg::ADDR_W-1:0]    pool_base = '0;

    map_req_t                        map_requests [$];
    map_result_t                     expected_results [$];
    logic [PATH_W-1:0]               known_paths [$];

    int                              items_queued   = 0;
    int                              items_accepted = 0;
    int                              base_writes    = 0;
    int                              mapped_seen    = 0;
    int                              refused_seen   = 0;
    int                              errors         = 0;

    bit                              item_taken = 1'b0;
    int                              burst_left = 1;
    int                              gap_left   = 0;
    map_req_t                        next_req;
    logic                            pred_status;
    logic [fltpm_pkg::ADDED_W-1:0]   pred_added;
    map_result_t                     exp_result;

    four_level_page_table_mapper u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .virt_addr    (virt_addr),
        .phys_addr    (phys_addr),
        .flags        (flags),
        .done         (done),
        .status       (status),
        .tables_added (tables_added),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .table_base   (table_base)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop: covers a hung walk, a lost result or a stuck busy.
    initial
    begin
        #15_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Walk the shadow tables for one request, allocating missing tables and
    // writing the leaf, exactly as the block should.
    function automatic void map_page(input logic [fltpm_pkg::VA_W-1:0] va,
                                     input logic [fltpm_pkg::ADDR_W-1:0] pa,
                                     input logic [fltpm_pkg::FLAGS_W-1:0] fl,
                                     output logic st,
                                     output logic [fltpm_pkg::ADDED_W-1:0] added);
        logic [fltpm_pkg::ADDR_W-1:0] base_al;
        logic [fltpm_pkg::ADDR_W-1:0] entry;
        logic [fltpm_pkg::ADDR_W-1:0] offset;
        logic [fltpm_pkg::IDX_W-1:0]  idx;
        int                           frame;
        int                           level;
        int                           n_added;
        // The low 12 bits of the pool base never take part.
        base_al = {pool_base[fltpm_pkg::ADDR_W-1:fltpm_pkg::PAGE_SHIFT],
                   {fltpm_pkg::PAGE_SHIFT{1'b0}}};
        frame   = 0;
        n_added = 0;
        st      = STATUS_MAPPED;
        for (level = int'(fltpm_pkg::LEVEL_TOP);
             level >= int'(fltpm_pkg::LEVEL_LAST) && st == STATUS_MAPPED;
             level--)
        begin
            idx   = va[fltpm_pkg::PAGE_SHIFT + fltpm_pkg::IDX_W * level
                       +: fltpm_pkg::IDX_W];
            entry = page_tables[frame * fltpm_pkg::ENTRIES_PER_TABLE + idx];
            if (entry[fltpm_pkg::PRESENT_BIT])
            begin
                // Turn the pointer back into a frame; it wraps in 52 bits and
                // folds into the pool, so stale pointers land somewhere valid.
                offset = {entry[fltpm_pkg::ADDR_W-1:fltpm_pkg::PAGE_SHIFT],
                          {fltpm_pkg::PAGE_SHIFT{1'b0}}} - base_al;
                frame  = int'(offset[fltpm_pkg::PAGE_SHIFT +: fltpm_pkg::FRAME_W]);
            end
            else if (alloc_ptr >= fltpm_pkg::TABLE_FRAMES)
                st = fltpm_pkg::STATUS_FULL;
            else
            begin
                page_tables[frame * fltpm_pkg::ENTRIES_PER_TABLE + idx] =
                    (base_al + (fltpm_pkg::ADDR_W'(alloc_ptr) << fltpm_pkg::PAGE_SHIFT))
                    | fltpm_pkg::ADDR_W'(fltpm_pkg::TABLE_ENTRY_BITS);
                frame = alloc_ptr;
                alloc_ptr++;
                n_added++;
            end
        end
        if (st == STATUS_MAPPED)
            page_tables[frame * fltpm_pkg::ENTRIES_PER_TABLE
                        + va[fltpm_pkg::PAGE_SHIFT +: fltpm_pkg::IDX_W]] =
                pa | fltpm_pkg::ADDR_W'(fl);
        added = fltpm_pkg::ADDED_W'(n_added);
    endfunction

    function automatic logic [fltpm_pkg::VA_W-1:0] make_va(
        input logic [fltpm_pkg::IDX_W-1:0] i3,
        input logic [fltpm_pkg::IDX_W-1:0] i2,
        input logic [fltpm_pkg::IDX_W-1:0] i1,
        input logic [fltpm_pkg::IDX_W-1:0] i0,
        input logic [fltpm_pkg::PAGE_SHIFT-1:0] off);
        return {i3, i2, i1, i0, off};
    endfunction

    function automatic logic [fltpm_pkg::ADDR_W-1:0] rand52();
        return fltpm_pkg::ADDR_W'({$urandom, $urandom});
    endfunction

    function automatic void queue_map(input logic [fltpm_pkg::VA_W-1:0] va,
                                      input logic [fltpm_pkg::ADDR_W-1:0] pa,
                                      input logic [fltpm_pkg::FLAGS_W-1:0] fl);
        map_requests.push_back('{va: va, pa: pa, fl: fl});
        items_queued++;
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    // Write the pool base and hold valid until the block takes the transaction.
    task automatic set_table_base(input logic [fltpm_pkg::ADDR_W-1:0] value);
        int seen;
        seen = base_writes;
        @(negedge clk);
        cfg_valid  <= 1'b1;
        table_base <= value;
        wait (base_writes != seen);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Driver: pop pending requests at the falling edge, hold each until taken,
    // and insert random gaps between bursts so idle cycles land on every step
    // of the walk. Gaps of zero give back-to-back stretches.
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!(start && !item_taken))
        begin
            item_taken = 1'b0;
            if (gap_left != 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (map_requests.size() != 0)
            begin
                next_req = map_requests.pop_front();
                virt_addr <= next_req.va;
                phys_addr <= next_req.pa;
                flags     <= next_req.fl;
                start     <= 1'b1;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check each result strobe against the oldest expectation, then
    // predict any transaction taken at this edge and track base writes.
    // Results cannot be stalled, so there is nothing to drive on that side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result strobe with no request outstanding");
                else
                begin
                    exp_result = expected_results.pop_front();
                    if (status !== exp_result.status)
                        report_mismatch($sformatf("va %h: status %b, predicted %b",
                                                  exp_result.va, status, exp_result.status));
                    if (tables_added !== exp_result.added)
                        report_mismatch($sformatf("va %h: tables_added %0d, predicted %0d",
                                                  exp_result.va, tables_added,
                                                  exp_result.added));
                end
                if (status === fltpm_pkg::STATUS_FULL)
                    refused_seen++;
                else
                    mapped_seen++;
            end
            if (start && !busy)
            begin
                map_page(virt_addr, phys_addr, flags, pred_status, pred_added);
                expected_results.push_back('{va: virt_addr, status: pred_status,
                                             added: pred_added});
                if (pred_status == STATUS_MAPPED)
                    known_paths.push_back(virt_addr[fltpm_pkg::VA_W-1 -: PATH_W]);
                items_accepted++;
                item_taken = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                pool_base = table_base;
                base_writes++;
            end
        end
    end

    initial
    begin
        logic [fltpm_pkg::ADDR_W-1:0] phase_base [PHASES];
        logic [fltpm_pkg::ADDR_W-1:0] pa;
        logic [fltpm_pkg::VA_W-1:0]   va;
        int                           p;
        int                           k;
        int                           pick;
        int                           path_sel;

        // Extremes, an unaligned base with all low bits set, random aligned and unaligned
        // values, an aligned base near the top, then back to zero so the old pointers resolve.
        phase_base[0] = '0;
        phase_base[1] = BASE_TOP;
        phase_base[2] = fltpm_pkg::ADDR_W'('hFFF);
        phase_base[3] = rand52() & BASE_TOP;
        phase_base[4] = rand52() >> 1;
        phase_base[5] = BASE_TOP - fltpm_pkg::ADDR_W'(32'h0001_F000);
        phase_base[6] = '0;

        for (k = 0; k < fltpm_pkg::MEM_DEPTH; k++)
            page_tables[k] = '0;

        rst_n      = 1'b0;
        start      = 1'b0;
        virt_addr  = '0;
        phys_addr  = '0;
        flags      = '0;
        cfg_valid  = 1'b0;
        table_base = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (p = 0; p < PHASES; p++)
        begin
            set_table_base(phase_base[p]);

            if (p == 0)
            begin
                // Fresh walk from an empty top level, then the all-ones address.
                queue_map(make_va(0, 0, 0, 0, 0), '0, '0);
                queue_map('1, '1, '1);
                // Overwrite a mapped leaf, then reuse the path at each depth.
                queue_map(make_va(0, 0, 0, 0, 0), rand52(), fltpm_pkg::FLAGS_W'(3));
                queue_map(make_va(0, 0, 0, 5, 'h800), rand52(), fltpm_pkg::FLAGS_W'(1));
                queue_map(make_va(0, 0, 1, 7, 0), rand52(), fltpm_pkg::FLAGS_W'($urandom));
                queue_map(make_va(0, 1, 0, 0, 0), rand52(), fltpm_pkg::FLAGS_W'($urandom));
                queue_map(make_va(0, 1, 1, 0, 0), rand52(), fltpm_pkg::FLAGS_W'($urandom));
                // Drain the pool: tops 1..17 leave two frames, top 18 takes
                // both and then runs dry, top 19 finds nothing at all.
                for (k = 1; k <= 19; k++)
                    queue_map(make_va(fltpm_pkg::IDX_W'(k), fltpm_pkg::IDX_W'($urandom),
                                      fltpm_pkg::IDX_W'($urandom),
                                      fltpm_pkg::IDX_W'($urandom),
                                      fltpm_pkg::PAGE_SHIFT'($urandom)),
                              rand52(), fltpm_pkg::FLAGS_W'($urandom));
                // An existing path still maps with the pool empty.
                queue_map(make_va(0, 1, 1, 9, 0), rand52(), fltpm_pkg::FLAGS_W'($urandom));
                wait (items_accepted == items_queued && expected_results.size() == 0);
            end

            // Mostly known paths with random leaves, some with a random
            // level-1 index under a known level-2 table, the rest pure noise.
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                pick = $urandom_range(0, 99);
                va   = fltpm_pkg::VA_W'({$urandom, $urandom});
                if (pick < 85 && known_paths.size() != 0)
                begin
                    path_sel = $urandom_range(0, known_paths.size() - 1);
                    if (pick < 65)
                        va[fltpm_pkg::VA_W-1 -: PATH_W] = known_paths[path_sel];
                    else
                        va[fltpm_pkg::VA_W-1 -: PATH_W - fltpm_pkg::IDX_W] =
                            known_paths[path_sel][PATH_W-1:fltpm_pkg::IDX_W];
                end
                case ($urandom_range(0, 15))
                    0:       pa = '0;
                    1:       pa = '1;
                    default: pa = rand52();
                endcase
                queue_map(va, pa, fltpm_pkg::FLAGS_W'($urandom));
            end

            // Let every transaction of this phase come back before touching
            // the base again.
            wait (items_accepted == items_queued && expected_results.size() == 0);
        end

        // Give a stray late strobe time to show up.
        repeat (20) @(posedge clk);

        $display("Run covered %0d map requests under %0d table base settings,",
                 items_accepted, base_writes);
        $display("with %0d pages mapped and %0d requests refused for lack of table frames.",
                 mapped_seen, refused_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
